/* hdl/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants for the edit distance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

  localparam int CHAR_W = 8;
  localparam int DIST_W = 7;

  // request modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_EMIT
  } state_t;

  // token and query character handed from cell to cell
  typedef struct packed {
    logic              tok;
    logic [CHAR_W-1:0] qch;
  } wave_t;

endpackage

`default_nettype wire

/* hdl/sed_cell.sv */
// ----------------------------------------------------------------------------
// sed_cell
// One column cell: holds a reference character and its row entry, and
// updates the entry when the query token passes through.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_cell #(
  parameter int DW = 7,
  parameter int K  = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rearm,
  input  wire logic                          clr,
  input  wire logic                          wr_en,
  input  wire logic [sed_pkg::CHAR_W-1:0]    wr_ch,
  input  wire sed_pkg::wave_t                wave_i,
  input  wire logic [DW-1:0]                 left_new,
  input  wire logic [DW-1:0]                 left_old,
  output sed_pkg::wave_t                     wave_o,
  output logic [DW-1:0]                      val_o,
  output logic [DW-1:0]                      prev_o
);

  logic                       has_r;
  logic                       tok_r;
  logic [sed_pkg::CHAR_W-1:0] ch_r;
  logic [sed_pkg::CHAR_W-1:0] qch_r;
  logic [DW-1:0]              val_r;
  logic [DW-1:0]              prev_r;

  logic          fire;
  logic [DW:0]   c_up;
  logic [DW:0]   c_left;
  logic [DW:0]   c_diag;
  logic [DW:0]   m1;
  logic [DW:0]   m2;

  assign fire   = wave_i.tok & has_r;
  assign c_up   = {1'b0, val_r} + {{DW{1'b0}}, 1'b1};
  assign c_left = {1'b0, left_new} + {{DW{1'b0}}, 1'b1};
  assign c_diag = {1'b0, left_old} + {{DW{1'b0}}, (ch_r != wave_i.qch)};
  assign m1     = (c_up < c_left) ? c_up : c_left;
  assign m2     = (m1 < c_diag) ? m1 : c_diag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_r <= 1'b0;
      tok_r <= 1'b0;
      val_r <= DW'(K + 1);
    end else begin
      tok_r <= fire;
      if (clr) begin
        has_r <= 1'b0;
      end else if (wr_en) begin
        has_r <= 1'b1;
      end
      if (rearm) begin
        val_r <= DW'(K + 1);
      end else if (fire) begin
        val_r <= m2[DW-1:0];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ch_r <= wr_ch;
    end
    if (fire) begin
      prev_r <= val_r;
      qch_r  <= wave_i.qch;
    end
  end

  assign wave_o.tok = tok_r;
  assign wave_o.qch = qch_r;
  assign val_o      = val_r;
  assign prev_o     = prev_r;

endmodule

`default_nettype wire

/* hdl/string_edit_distance_top.sv */
// ----------------------------------------------------------------------------
// string_edit_distance_top
// Levenshtein distance between a stored reference and a streamed query,
// computed by a row of cells that a query token sweeps once per character.
// ----------------------------------------------------------------------------
// query character: token walks n cells, n the reference length; input stalls
// clear, append and dropped query characters: no wave runs
// last query character or end request: the emit state waits for a stalled
// output register, then loads the result
// reset (synchronous): lengths and drop flag zero, row rearmed to 0..MAX_LEN
`default_nettype none

module string_edit_distance_top #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_mode,
  input  wire logic [sed_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic                           in_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [sed_pkg::DIST_W-1:0]          out_edit_distance,
  output logic                                out_overflow
);

  localparam int DW     = $clog2(MAX_LEN + 1);
  localparam int DIST_W = sed_pkg::DIST_W;

  sed_pkg::state_t state_r, state_nxt;

  logic [DW-1:0]              ref_len_r;
  logic [DW-1:0]              q_len_r;
  logic [DW-1:0]              q_prev_r;
  logic [DW-1:0]              cnt_r;
  logic                       drop_r;
  logic                       last_r;
  logic                       inj_tok_r;
  logic [sed_pkg::CHAR_W-1:0] inj_qch_r;
  logic                       out_valid_r;
  logic [DIST_W-1:0]          out_dist_r;
  logic                       out_ovf_r;

  // control decode
  logic accept;
  logic is_clear;
  logic is_append;
  logic is_query;
  logic ref_full;
  logic q_full;
  logic fire_q;
  logic wr_en;
  logic rearm;
  logic emit_go;
  logic out_free;

  // chain wiring, entry 0 is the left edge fed by the controller
  sed_pkg::wave_t wave   [0:MAX_LEN];
  logic [DW-1:0]  new_v  [0:MAX_LEN];
  logic [DW-1:0]  old_v  [0:MAX_LEN];
  logic [MAX_LEN-1:0] tok_vec;

  logic [DW-1:0] dist_full;

  assign accept    = in_valid && !in_stall;
  assign is_clear  = (in_mode == sed_pkg::MODE_CLEAR);
  assign is_append = (in_mode == sed_pkg::MODE_APPEND);
  assign is_query  = (in_mode == sed_pkg::MODE_QUERY);
  assign ref_full  = (ref_len_r == DW'(MAX_LEN));
  assign q_full    = (q_len_r == DW'(MAX_LEN));
  assign fire_q    = accept && is_query && !q_full;
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sed_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            sed_pkg::MODE_QUERY: begin
              if (fire_q && (ref_len_r != '0)) begin
                state_nxt = sed_pkg::ST_WAVE;
              end else if (in_last) begin
                state_nxt = sed_pkg::ST_EMIT;
              end
            end
            sed_pkg::MODE_END: begin
              state_nxt = sed_pkg::ST_EMIT;
            end
            default: begin
              state_nxt = sed_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sed_pkg::ST_WAVE: begin
        // token reaches the last reference cell
        if (cnt_r == ref_len_r) begin
          state_nxt = last_r ? sed_pkg::ST_EMIT : sed_pkg::ST_IDLE;
        end
      end
      sed_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = sed_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sed_pkg::ST_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall = 1'b1;
    emit_go  = 1'b0;
    unique case (state_r)
      sed_pkg::ST_IDLE: in_stall = 1'b0;
      sed_pkg::ST_WAVE: in_stall = 1'b1;
      sed_pkg::ST_EMIT: emit_go  = out_free;
      default:          in_stall = 1'b1;
    endcase
  end

  assign wr_en = accept && is_append && !ref_full;
  // a new reference char or clear abandons the query; an emit rearms
  assign rearm = (accept && (is_clear || is_append)) || emit_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sed_pkg::ST_IDLE;
      ref_len_r   <= '0;
      q_len_r     <= '0;
      drop_r      <= 1'b0;
      inj_tok_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      inj_tok_r <= fire_q;

      // reference length and sticky drop mark
      if (accept && is_clear) begin
        ref_len_r <= '0;
        drop_r    <= 1'b0;
      end else if (wr_en) begin
        ref_len_r <= ref_len_r + DW'(1);
      end else if (accept && ((is_append && ref_full) || (is_query && q_full))) begin
        drop_r <= 1'b1;
      end

      // query length doubles as row entry zero
      if (rearm) begin
        q_len_r <= '0;
      end else if (fire_q) begin
        q_len_r <= q_len_r + DW'(1);
      end

      if (accept) begin
        last_r <= in_last;
      end

      // wave position counter
      if (fire_q) begin
        cnt_r <= DW'(1);
      end else if (state_r == sed_pkg::ST_WAVE) begin
        cnt_r <= cnt_r + DW'(1);
      end

      // result register
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (fire_q) begin
      q_prev_r  <= q_len_r;
      inj_qch_r <= in_char_code;
    end
    if (emit_go) begin
      out_dist_r <= DIST_W'(dist_full);
      out_ovf_r  <= drop_r;
    end
  end

  // left edge of the chain: new and old value of row entry zero
  assign wave[0].tok = inj_tok_r;
  assign wave[0].qch = inj_qch_r;
  assign new_v[0]    = q_len_r;
  assign old_v[0]    = q_prev_r;

  genvar k;
  generate
    for (k = 0; k < MAX_LEN; k++) begin : g_cell
      sed_cell #(
        .DW (DW),
        .K  (k)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .rearm    (rearm),
        .clr      (accept && is_clear),
        .wr_en    (wr_en && (ref_len_r == DW'(k))),
        .wr_ch    (in_char_code),
        .wave_i   (wave[k]),
        .left_new (new_v[k]),
        .left_old (old_v[k]),
        .wave_o   (wave[k+1]),
        .val_o    (new_v[k+1]),
        .prev_o   (old_v[k+1])
      );
      assign tok_vec[k] = wave[k+1].tok;
    end
  endgenerate

  // row entry at the reference length; entry zero is the query length
  assign dist_full = new_v[ref_len_r];

  assign out_valid         = out_valid_r;
  assign out_edit_distance = out_dist_r;
  assign out_overflow      = out_ovf_r;

  // only one query token is ever in flight along the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one token in the cell chain");

  // the wave never runs past the reference
  a_wave_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sed_pkg::ST_WAVE) |-> (cnt_r <= ref_len_r) && (ref_len_r != '0))
    else $error("wave counter beyond reference length");

  // a result appears only from the emit state
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == sed_pkg::ST_EMIT))
    else $error("result loaded outside emit");

  // rearm never meets a firing wave
  a_no_rearm_in_wave: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sed_pkg::ST_WAVE) |-> !rearm)
    else $error("row rearmed during a wave");

endmodule

`default_nettype wire
